// File: design/ppg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the pinhole primary ray generator.
// Used by the top level, the square-root pipeline and the divider pipeline.
package ppg_pkg;

  localparam int PPG_MAX_DIM_BITS = 13;

  // Normalized component magnitudes lie in [0, 2^31).
  localparam int NORM_W   = 31;
  localparam int SQ_W     = 64;
  localparam int ROOT_W   = 32;
  localparam int DIR_W    = 32;
  localparam int NORM_POS = 30;

  localparam logic [NORM_W-1:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [DIR_W-1:0]  DIR_ONE  = 32'h4000_0000;
  localparam logic [DIR_W-1:0]  DIR_MONE = 32'hC000_0000;

  typedef enum logic [2:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_CENTER_Z     = 3'd2,
    REG_FOCAL_LENGTH = 3'd3,
    REG_IMAGE_WIDTH  = 3'd4,
    REG_IMAGE_HEIGHT = 3'd5
  } ppg_reg_t;

  // Per-item data that travels beside the square root.
  typedef struct packed {
    logic              zero;
    logic              neg_x;
    logic              neg_y;
    logic [NORM_W-1:0] mag_x;
    logic [NORM_W-1:0] mag_y;
    logic [NORM_W-1:0] mag_z;
  } ppg_side_t;

  typedef struct packed {
    logic [DIR_W-1:0] x;
    logic [DIR_W-1:0] y;
    logic [DIR_W-1:0] z;
  } ppg_dir_t;

endpackage

// File: design/pinhole_primary_ray_generator_unit.sv
`timescale 1ns / 1ps
// Pinhole camera primary ray generator: origin plus unit direction per sample.
// Throughput is one sample per cycle while the skid entry is empty; the 32-stage
// square root and the 33-stage dividers are fully pipelined, so the depth sets
// only the latency. Synchronous active-low reset empties the pipeline and loads
// the default camera registers; no stage needs a clearing pass.
module pinhole_primary_ray_generator_unit import ppg_pkg::*; #(
  parameter int MAX_DIM_BITS = PPG_MAX_DIM_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [31:0]             cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [MAX_DIM_BITS-1:0] in_pixel_x,
  input  logic [MAX_DIM_BITS-1:0] in_pixel_y,
  input  logic [15:0]             in_jitter_x,
  input  logic [15:0]             in_jitter_y,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [31:0]             out_origin_x,
  output logic [31:0]             out_origin_y,
  output logic [31:0]             out_origin_z,
  output logic [DIR_W-1:0]        out_dir_x,
  output logic [DIR_W-1:0]        out_dir_y,
  output logic [DIR_W-1:0]        out_dir_z
);

  localparam int DIM_W = MAX_DIM_BITS + 1;
  localparam int POS_W = MAX_DIM_BITS + 16;
  localparam int NX_W  = MAX_DIM_BITS + 18;
  localparam int AX_W  = MAX_DIM_BITS + 17;
  localparam int AZ_W  = MAX_DIM_BITS + 32;
  localparam int P_W   = $clog2(AZ_W);
  localparam int SH_W  = AZ_W + NORM_POS;

  // Camera registers.
  logic [31:0]      center_x_r, center_y_r, center_z_r;
  logic [30:0]      focal_r;
  logic [DIM_W-1:0] width_r, height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      center_z_r <= '0;
      focal_r    <= 31'd65536;
      width_r    <= DIM_W'(640);
      height_r   <= DIM_W'(480);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CENTER_X:     center_x_r <= cfg_data;
        REG_CENTER_Y:     center_y_r <= cfg_data;
        REG_CENTER_Z:     center_z_r <= cfg_data;
        REG_FOCAL_LENGTH: focal_r    <= cfg_data[30:0];
        REG_IMAGE_WIDTH:  width_r    <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_r   <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_v_r;
  assign en       = !skid_v_r;
  assign in_ready = en;

  // Stage 1: offsets from the viewport center, magnitudes and signs.
  logic [DIM_W-1:0] h_eff;
  logic [NX_W-1:0]  nx, ny, abs_x, abs_y;
  logic [AZ_W-1:0]  az_nxt;
  logic             s1_v_r, s1_sx_r, s1_sy_r;
  logic [AX_W-1:0]  s1_ax_r, s1_ay_r;
  logic [AZ_W-1:0]  s1_az_r;

  always_comb begin
    h_eff  = (height_r == '0) ? DIM_W'(1) : height_r;
    nx     = NX_W'({in_pixel_x, in_jitter_x}) - NX_W'({width_r, 15'b0});
    ny     = NX_W'({h_eff, 15'b0}) - NX_W'({in_pixel_y, in_jitter_y});
    abs_x  = nx[NX_W-1] ? NX_W'(-nx) : nx;
    abs_y  = ny[NX_W-1] ? NX_W'(-ny) : ny;
    az_nxt = AZ_W'(focal_r) * AZ_W'(h_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sx_r <= nx[NX_W-1];
      s1_sy_r <= ny[NX_W-1];
      s1_ax_r <= {abs_x[POS_W-1:0], 1'b0};
      s1_ay_r <= {abs_y[POS_W-1:0], 1'b0};
      s1_az_r <= az_nxt;
    end
  end

  // Stage 2: the leading one of the OR of the magnitudes is that of their maximum.
  logic [AZ_W-1:0] or_all;
  logic [P_W-1:0]  lead_nxt;
  logic            s2_v_r, s2_sx_r, s2_sy_r, s2_zero_r;
  logic [AZ_W-1:0] s2_ax_r, s2_ay_r, s2_az_r;
  logic [P_W-1:0]  s2_lead_r;

  always_comb begin
    or_all   = AZ_W'(s1_ax_r) | AZ_W'(s1_ay_r) | s1_az_r;
    lead_nxt = '0;
    for (int i = 0; i < AZ_W; i++) begin
      if (or_all[i]) lead_nxt = P_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sx_r   <= s1_sx_r;
      s2_sy_r   <= s1_sy_r;
      s2_zero_r <= (or_all == '0);
      s2_ax_r   <= AZ_W'(s1_ax_r);
      s2_ay_r   <= AZ_W'(s1_ay_r);
      s2_az_r   <= s1_az_r;
      s2_lead_r <= lead_nxt;
    end
  end

  // Stage 3: common shift that puts the largest magnitude in [2^30, 2^31).
  logic [SH_W-1:0] sh_x, sh_y, sh_z;
  ppg_side_t       side_nxt;
  logic            s3_v_r;
  ppg_side_t       s3_side_r;

  always_comb begin
    sh_x           = {s2_ax_r, {NORM_POS{1'b0}}} >> s2_lead_r;
    sh_y           = {s2_ay_r, {NORM_POS{1'b0}}} >> s2_lead_r;
    sh_z           = {s2_az_r, {NORM_POS{1'b0}}} >> s2_lead_r;
    side_nxt.zero  = s2_zero_r;
    side_nxt.neg_x = s2_sx_r;
    side_nxt.neg_y = s2_sy_r;
    side_nxt.mag_x = sh_x[NORM_W-1:0];
    side_nxt.mag_y = sh_y[NORM_W-1:0];
    side_nxt.mag_z = sh_z[NORM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side_r <= side_nxt;
    end
  end

  // Stage 4: squares.
  logic                s4_v_r;
  ppg_side_t           s4_side_r;
  logic [2*NORM_W-1:0] s4_sqx_r, s4_sqy_r, s4_sqz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side_r <= s3_side_r;
      s4_sqx_r  <= s3_side_r.mag_x * s3_side_r.mag_x;
      s4_sqy_r  <= s3_side_r.mag_y * s3_side_r.mag_y;
      s4_sqz_r  <= s3_side_r.mag_z * s3_side_r.mag_z;
    end
  end

  // Stage 5: sum of squares.
  logic            s5_v_r;
  ppg_side_t       s5_side_r;
  logic [SQ_W-1:0] s5_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_side_r <= s4_side_r;
      s5_sum_r  <= SQ_W'(s4_sqx_r) + SQ_W'(s4_sqy_r) + SQ_W'(s4_sqz_r);
    end
  end

  logic              sq_v;
  logic [ROOT_W-1:0] sq_root;
  ppg_side_t         sq_side;

  ppg_sqrt_pipe u_sqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (s5_v_r),
    .in_radicand(s5_sum_r),
    .in_side    (s5_side_r),
    .out_valid  (sq_v),
    .out_root   (sq_root),
    .out_side   (sq_side)
  );

  logic     dv_x, dv_y, dv_z;
  ppg_dir_t pipe_dir;

  ppg_div_pipe u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (sq_v),
    .in_mag   (sq_side.mag_x),
    .in_root  (sq_root),
    .in_neg   (sq_side.neg_x),
    .in_zero  (sq_side.zero),
    .out_valid(dv_x),
    .out_dir  (pipe_dir.x)
  );

  ppg_div_pipe u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (sq_v),
    .in_mag   (sq_side.mag_y),
    .in_root  (sq_root),
    .in_neg   (sq_side.neg_y),
    .in_zero  (sq_side.zero),
    .out_valid(dv_y),
    .out_dir  (pipe_dir.y)
  );

  ppg_div_pipe u_div_z (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (sq_v),
    .in_mag   (sq_side.mag_z),
    .in_root  (sq_root),
    .in_neg   (1'b1),
    .in_zero  (sq_side.zero),
    .out_valid(dv_z),
    .out_dir  (pipe_dir.z)
  );

  // Output register with a skid entry behind it. The pipeline stalls only
  // when the skid entry is occupied, so ready never depends on out_ready.
  logic     pipe_v;
  logic     out_v_r, out_v_nxt, skid_v_nxt;
  logic     load_from_skid, load_from_pipe, load_skid;
  ppg_dir_t out_dir_r, skid_dir_r;

  assign pipe_v = dv_x && dv_y && dv_z;

  always_comb begin
    out_v_nxt      = out_v_r;
    skid_v_nxt     = skid_v_r;
    load_from_skid = 1'b0;
    load_from_pipe = 1'b0;
    load_skid      = 1'b0;
    if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_v_nxt      = 1'b1;
        skid_v_nxt     = 1'b0;
        load_from_skid = 1'b1;
      end else if (pipe_v && en) begin
        out_v_nxt      = 1'b1;
        load_from_pipe = 1'b1;
      end else begin
        out_v_nxt = 1'b0;
      end
    end else if (pipe_v && en) begin
      skid_v_nxt = 1'b1;
      load_skid  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_from_skid) begin
      out_dir_r <= skid_dir_r;
    end else if (load_from_pipe) begin
      out_dir_r <= pipe_dir;
    end
    if (load_skid) begin
      skid_dir_r <= pipe_dir;
    end
  end

  // Origin = camera center; user changes it only while block is idle (unenforced).
  assign out_valid    = out_v_r;
  assign out_origin_x = center_x_r;
  assign out_origin_y = center_y_r;
  assign out_origin_z = center_z_r;
  assign out_dir_x    = out_dir_r.x;
  assign out_dir_y    = out_dir_r.y;
  assign out_dir_z    = out_dir_r.z;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry holds a result while the output register is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_ready) |=> (out_v_r && !skid_v_r))
    else $error("skid entry did not move into the output register");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (($signed(out_dir_r.x) <= $signed(DIR_ONE)) &&
                 ($signed(out_dir_r.x) >= $signed(DIR_MONE)) &&
                 ($signed(out_dir_r.y) <= $signed(DIR_ONE)) &&
                 ($signed(out_dir_r.y) >= $signed(DIR_MONE))))
    else $error("direction component beyond unit magnitude");

  a_dir_z_not_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (($signed(out_dir_r.z) <= 0) &&
                 ($signed(out_dir_r.z) >= $signed(DIR_MONE))))
    else $error("z direction points away from the viewport");

endmodule

// File: design/ppg_sqrt_pipe.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage (32 stages).
// Depends on ppg_pkg for widths and the side-band struct.
module ppg_sqrt_pipe import ppg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   in_radicand,
  input  ppg_side_t         in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output ppg_side_t         out_side
);

  logic              v_r    [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  ppg_side_t         side_r [ROOT_W];
  logic [SQ_W-1:0]   x_r    [ROOT_W-1];
  logic [ROOT_W+1:0] rem_r  [ROOT_W-1];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              v_in;
    logic [SQ_W-1:0]   x_in;
    logic [ROOT_W+1:0] rem_in;
    logic [ROOT_W-1:0] root_in;
    ppg_side_t         side_in;
    logic [ROOT_W+3:0] cand;
    logic [ROOT_W+3:0] trial;
    logic              fit;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign x_in    = in_radicand;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_rest
      assign v_in    = v_r[k-1];
      assign x_in    = x_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign cand  = {rem_in, x_in[SQ_W-1-2*k -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign fit   = (cand >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= {root_in[ROOT_W-2:0], fit};
        side_r[k] <= side_in;
      end
    end

    if (k < ROOT_W - 1) begin : g_carry
      logic [ROOT_W+3:0] diff;
      assign diff = cand - trial;
      always_ff @(posedge clk) begin
        if (en) begin
          x_r[k]   <= x_in;
          rem_r[k] <= fit ? diff[ROOT_W+1:0] : cand[ROOT_W+1:0];
        end
      end
    end
  end

  assign out_valid = v_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_side  = side_r[ROOT_W-1];

endmodule

// File: design/ppg_div_pipe.sv
`timescale 1ns / 1ps
// Pipelined restoring divider giving round(m * 2^30 / n), saturated at 1.0,
// with sign and zero handling. One quotient bit per stage. Depends on ppg_pkg.
module ppg_div_pipe import ppg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NORM_W-1:0] in_mag,
  input  logic [ROOT_W-1:0] in_root,
  input  logic              in_neg,
  input  logic              in_zero,
  output logic              out_valid,
  output logic [DIR_W-1:0]  out_dir
);

  localparam int D_W = NORM_W + NORM_POS + 1;

  logic [D_W-1:0] dividend;

  logic              pv_r;
  logic [ROOT_W-1:0] prem_r;
  logic [NORM_W-1:0] plow_r;
  logic [ROOT_W-1:0] pn_r;
  logic              pneg_r;
  logic              pzero_r;

  // Dividend is m * 2^30 + n / 2; its upper bits seed the remainder.
  assign dividend = {1'b0, in_mag, {NORM_POS{1'b0}}} + D_W'(in_root[ROOT_W-1:1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (en) begin
      pv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prem_r  <= ROOT_W'(dividend[D_W-1:NORM_W]);
      plow_r  <= dividend[NORM_W-1:0];
      pn_r    <= in_root;
      pneg_r  <= in_neg;
      pzero_r <= in_zero;
    end
  end

  logic              v_r    [NORM_W];
  logic [ROOT_W-1:0] rem_r  [NORM_W];
  logic [NORM_W-1:0] low_r  [NORM_W];
  logic [ROOT_W-1:0] n_r    [NORM_W];
  logic [NORM_W-1:0] q_r    [NORM_W];
  logic              neg_r  [NORM_W];
  logic              zero_r [NORM_W];

  for (genvar i = 0; i < NORM_W; i++) begin : g_stage
    logic              v_in;
    logic [ROOT_W-1:0] rem_in;
    logic [NORM_W-1:0] low_in;
    logic [ROOT_W-1:0] n_in;
    logic [NORM_W-1:0] q_in;
    logic              neg_in;
    logic              zero_in;
    logic [ROOT_W:0]   cand;
    logic [ROOT_W:0]   diff;
    logic              fit;

    if (i == 0) begin : g_first
      assign v_in    = pv_r;
      assign rem_in  = prem_r;
      assign low_in  = plow_r;
      assign n_in    = pn_r;
      assign q_in    = '0;
      assign neg_in  = pneg_r;
      assign zero_in = pzero_r;
    end else begin : g_rest
      assign v_in    = v_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign low_in  = low_r[i-1];
      assign n_in    = n_r[i-1];
      assign q_in    = q_r[i-1];
      assign neg_in  = neg_r[i-1];
      assign zero_in = zero_r[i-1];
    end

    assign cand = {rem_in, low_in[NORM_W-1-i]};
    assign fit  = (cand >= {1'b0, n_in});
    assign diff = cand - {1'b0, n_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= fit ? diff[ROOT_W-1:0] : cand[ROOT_W-1:0];
        low_r[i]  <= low_in;
        n_r[i]    <= n_in;
        q_r[i]    <= {q_in[NORM_W-2:0], fit};
        neg_r[i]  <= neg_in;
        zero_r[i] <= zero_in;
      end
    end
  end

  logic [NORM_W-1:0] q_sat;
  logic [DIR_W-1:0]  mag_ext;
  logic [DIR_W-1:0]  dir_nxt;
  logic              dv_r;
  logic [DIR_W-1:0]  dir_r;

  always_comb begin
    q_sat   = (q_r[NORM_W-1] > ONE_Q30) ? ONE_Q30 : q_r[NORM_W-1];
    mag_ext = {1'b0, q_sat};
    if (zero_r[NORM_W-1]) begin
      dir_nxt = '0;
    end else if (neg_r[NORM_W-1]) begin
      dir_nxt = DIR_W'(-mag_ext);
    end else begin
      dir_nxt = mag_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= 1'b0;
    end else if (en) begin
      dv_r <= v_r[NORM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dir_r <= dir_nxt;
    end
  end

  assign out_valid = dv_r;
  assign out_dir   = dir_r;

endmodule

// File: sim/pinhole_primary_ray_generator_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the pinhole primary ray generator.
// Depends on ppg_pkg and pinhole_primary_ray_generator_unit only.
module pinhole_primary_ray_generator_unit_test import ppg_pkg::*; ();

  localparam int LATENCY = 70;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [31:0] org_x, org_y, org_z;
    logic [31:0] dir_x, dir_y, dir_z;
  } ray_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [12:0] in_pixel_x = '0, in_pixel_y = '0;
  logic [15:0] in_jitter_x = '0, in_jitter_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_origin_x, out_origin_y, out_origin_z;
  logic [31:0] out_dir_x, out_dir_y, out_dir_z;

  // Camera registers as the block should hold them.
  logic [31:0] cam_x = 0, cam_y = 0, cam_z = 0;
  logic [30:0] cam_focal = 31'd65536;
  logic [13:0] cam_width = 14'd640, cam_height = 14'd480;

  ray_t pending_rays[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold = 0;

  pinhole_primary_ray_generator_unit dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res, bits;
    res = 0;
    bits = 64'd1 << 62;
    while (bits > x) bits = bits >> 2;
    while (bits != 0) begin
      if (x >= res + bits) begin
        x = x - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res;
  endfunction

  // Rounded, saturated quotient m/n in Q1.30 with the sign applied.
  function automatic logic [31:0] unit_component(logic [63:0] m, logic [63:0] n, bit neg);
    logic [63:0] q;
    q = ((m << 30) + (n >> 1)) / n;
    if (q > (64'd1 << 30)) q = 64'd1 << 30;
    return neg ? 32'(-q) : q[31:0];
  endfunction

  function automatic ray_t predict_ray(logic [12:0] u, logic [12:0] v,
                                       logic [15:0] jx, logic [15:0] jy);
    ray_t r;
    longint nx, ny, ul, vl, wl, hl;
    logic [63:0] ax, ay, az, mx, n;
    bit sx, sy;
    ul = u;
    vl = v;
    wl = cam_width;
    hl = (cam_height == 0) ? 1 : cam_height;
    nx = ul * 65536 + longint'(jx) - wl * 32768;
    ny = hl * 32768 - (vl * 65536 + longint'(jy));
    sx = nx < 0;
    sy = ny < 0;
    ax = 2 * (sx ? -nx : nx);
    ay = 2 * (sy ? -ny : ny);
    az = 64'(cam_focal) * 64'(hl);
    mx = ax;
    if (ay > mx) mx = ay;
    if (az > mx) mx = az;
    r.org_x = cam_x;
    r.org_y = cam_y;
    r.org_z = cam_z;
    r.dir_x = 0;
    r.dir_y = 0;
    r.dir_z = 0;
    if (mx != 0) begin
      while (mx >= (64'd1 << 31)) begin
        mx >>= 1; ax >>= 1; ay >>= 1; az >>= 1;
      end
      while (mx < (64'd1 << 30)) begin
        mx <<= 1; ax <<= 1; ay <<= 1; az <<= 1;
      end
      n = int_sqrt(ax * ax + ay * ay + az * az);
      r.dir_x = unit_component(ax, n, sx);
      r.dir_y = unit_component(ay, n, sy);
      r.dir_z = unit_component(az, n, 1'b1);
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
  endtask

  // Result checker.
  always @(posedge clk) begin
    ray_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rays.size() == 0) begin
        report("unexpected ray", out_dir_x, 32'h0);
      end else begin
        e = pending_rays.pop_front();
        if (out_origin_x !== e.org_x) report("origin_x", out_origin_x, e.org_x);
        if (out_origin_y !== e.org_y) report("origin_y", out_origin_y, e.org_y);
        if (out_origin_z !== e.org_z) report("origin_z", out_origin_z, e.org_z);
        if (out_dir_x !== e.dir_x) report("dir_x", out_dir_x, e.dir_x);
        if (out_dir_y !== e.dir_y) report("dir_y", out_dir_y, e.dir_y);
        if (out_dir_z !== e.dir_z) report("dir_z", out_dir_z, e.dir_z);
      end
    end
  end

  // Result side flow control, with an optional long hold-off.
  always @(posedge clk) begin
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  task automatic write_reg(ppg_reg_t idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CENTER_X:     cam_x = value;
      REG_CENTER_Y:     cam_y = value;
      REG_CENTER_Z:     cam_z = value;
      REG_FOCAL_LENGTH: cam_focal = value[30:0];
      REG_IMAGE_WIDTH:  cam_width = value[13:0];
      REG_IMAGE_HEIGHT: cam_height = value[13:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_camera(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                            logic [31:0] focal, logic [31:0] w, logic [31:0] h);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_FOCAL_LENGTH, focal);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  task automatic send_sample(logic [12:0] u, logic [12:0] v,
                             logic [15:0] jx, logic [15:0] jy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_x <= u;
    in_pixel_y <= v;
    in_jitter_x <= jx;
    in_jitter_y <= jy;
    do @(posedge clk); while (!in_ready);
    pending_rays.push_back(predict_ray(u, v, jx, jy));
  endtask

  // Lowers valid, drains every pending ray, then lets the pipeline settle.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_rays.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic send_random_sample;
    logic [12:0] u, v;
    if ($urandom_range(3) == 0) begin
      u = 13'($urandom);
      v = 13'($urandom);
    end else begin
      u = 13'($urandom_range((cam_width > 8192 || cam_width == 0) ? 8191 : cam_width - 1));
      v = 13'($urandom_range((cam_height > 8192 || cam_height == 0) ? 8191 : cam_height - 1));
    end
    send_sample(u, v, 16'($urandom), 16'($urandom));
  endtask

  task automatic randomize_camera;
    logic [31:0] focal;
    focal = ($urandom >> $urandom_range(31)) & 32'h7FFF_FFFF;
    if (focal == 0) focal = 1;
    set_camera($urandom, $urandom, $urandom, focal,
               $urandom_range(2) == 0 ? $urandom_range(1, 64) : $urandom_range(1, 8192),
               $urandom_range(2) == 0 ? $urandom_range(1, 64) : $urandom_range(1, 8192));
  endtask

  task automatic test_defaults;
    send_sample(0, 0, 0, 0);
    send_sample(13'h1FFF, 13'h1FFF, 16'hFFFF, 16'hFFFF);
    send_sample(320, 240, 16'h8000, 16'h8000);
    send_sample(320, 240, 0, 0);
    send_sample(639, 0, 16'hFFFF, 0);
    send_sample(0, 479, 0, 16'hFFFF);
    send_sample(639, 479, 16'h1234, 16'hFEDC);
    drain();
  endtask

  task automatic test_extreme_cameras;
    set_camera(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 8192, 8192);
    send_sample(0, 0, 0, 0);
    send_sample(13'h1FFF, 13'h1FFF, 16'hFFFF, 16'hFFFF);
    send_sample(4096, 4096, 0, 0);
    drain();
    set_camera(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1, 1);
    send_sample(0, 0, 16'h8000, 16'h8000);
    send_sample(13'h1FFF, 0, 0, 16'hFFFF);
    drain();
    // A zero height acts as one; a zero width leaves the viewport with no width.
    set_camera(0, 0, 0, 65536, 0, 0);
    send_sample(0, 0, 0, 0);
    send_sample(100, 3, 16'hABCD, 16'h0001);
    drain();
    // With no focal distance the sample at the viewport center yields the zero vector.
    set_camera(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 0, 640, 480);
    send_sample(320, 240, 0, 0);
    send_sample(321, 240, 0, 0);
    send_sample(320, 239, 0, 16'hFFFF);
    drain();
  endtask

  task automatic test_random_phase(int count, int s_idle, int r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int i = 0; i < count; i++) begin
      if (i % 90 == 0) begin
        drain();
        randomize_camera();
      end
      send_random_sample();
    end
    drain();
  endtask

  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 400;
    for (int i = 0; i < 160; i++) send_random_sample();
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_extreme_cameras();
    test_random_phase(210, 31, 50);
    test_random_phase(210, 50, 31);
    test_random_phase(210, 0, 0);
    test_backpressure();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
design/ppg_pkg.sv
design/ppg_sqrt_pipe.sv
design/ppg_div_pipe.sv
design/pinhole_primary_ray_generator_unit.sv
sim/pinhole_primary_ray_generator_unit_test.sv
